FILE: src/stereo_tilt_equalizer_unit_macros.svh
// Assertion macros shared by the equalizer RTL.
`ifndef STEREO_TILT_EQUALIZER_UNIT_MACROS_SVH
`define STEREO_TILT_EQUALIZER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STEQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/steq_pkg.sv
// Shared types, constants and microcode ROM of the tilt equalizer.
`default_nettype none
package steq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS      = 18;
   localparam int GAIN_BITS      = 21;
   localparam int STATE_BITS     = 32;

   localparam int DIFF_BITS  = STATE_BITS + 1;
   localparam int Y_BITS     = COEF_BITS + DIFF_BITS + 2 - COEF_FRAC_BITS;
   localparam int MUL_A_BITS = GAIN_BITS + 1;
   localparam int MUL_B_BITS = (Y_BITS > DIFF_BITS) ? Y_BITS : DIFF_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS   = PROD_BITS + 1;
   localparam int RND_BITS   = ACC_BITS - COEF_FRAC_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = GAIN_BITS;

   localparam int UCODE_DEPTH = 12;
   localparam int PC_BITS     = $clog2(UCODE_DEPTH);

   typedef logic signed [SAMPLE_BITS-1:0]   sample_type;
   typedef logic signed [COEF_BITS-1:0]     coef_type;
   typedef logic        [GAIN_BITS-1:0]     gain_type;
   typedef logic signed [STATE_BITS-1:0]    state_type;
   typedef logic        [CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic        [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic        [PC_BITS-1:0]       pc_type;

   localparam gain_type UNITY_GAIN = gain_type'(1 << COEF_FRAC_BITS);
   localparam pc_type   PC_ENTRY   = '0;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MONO_MODE     = 3'd0,
      CSR_FEED_COEF     = 3'd1,
      CSR_FEEDBACK_COEF = 3'd2,
      CSR_LOW_GAIN      = 3'd3,
      CSR_HIGH_GAIN     = 3'd4,
      CSR_OUTPUT_GAIN   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic     mono_mode;
      coef_type feed_coef;
      coef_type feedback_coef;
      coef_type low_gain;
      coef_type high_gain;
      gain_type output_gain;
   } cfg_type;

   typedef enum logic [2:0] {A_FEED, A_FBACK, A_LOW, A_HIGH, A_OUT} mul_a_sel_type;
   typedef enum logic [1:0] {B_X, B_LP, B_DIFF, B_Y} mul_b_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_LP, WR_Y, WR_OUT} wr_op_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_CHAN, JMP_EMIT} jmp_type;

   typedef struct packed {
      logic          mul_en;
      mul_a_sel_type a_sel;
      mul_b_sel_type b_sel;
      acc_op_type    acc_op;
      wr_op_type     wr_op;
      jmp_type       jmp;
   } uword_type;

   typedef struct packed {
      logic          mul_en;
      mul_a_sel_type a_sel;
      mul_b_sel_type b_sel;
      acc_op_type    acc_op;
      wr_op_type     wr_op;
      logic          chan;
   } ctrl_type;

   typedef struct packed {
      logic busy;
      logic chan;
      logic emit;
   } seq_status_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       clip;
   } result_type;

   function automatic uword_type uw(logic mul_en, mul_a_sel_type a_sel,
                                    mul_b_sel_type b_sel, acc_op_type acc_op,
                                    wr_op_type wr_op, jmp_type jmp);
      uword_type w;
      w.mul_en = mul_en;
      w.a_sel  = a_sel;
      w.b_sel  = b_sel;
      w.acc_op = acc_op;
      w.wr_op  = wr_op;
      w.jmp    = jmp;
      return w;
   endfunction

   // One channel pass is steps 0..10; the jump at 10 reruns it for the right channel.
   function automatic uword_type ucode_rom(pc_type pc);
      uword_type w;
      w = uw(1'b0, A_FEED, B_X, ACC_HOLD, WR_NONE, JMP_NEXT);
      case (pc)
         0:  w = uw(1'b1, A_FEED,  B_X,    ACC_HOLD, WR_NONE, JMP_NEXT);
         1:  w = uw(1'b1, A_FBACK, B_LP,   ACC_LOAD, WR_NONE, JMP_NEXT);
         2:  w = uw(1'b0, A_FEED,  B_X,    ACC_ADD,  WR_NONE, JMP_NEXT);
         3:  w = uw(1'b0, A_FEED,  B_X,    ACC_HOLD, WR_LP,   JMP_NEXT);
         4:  w = uw(1'b1, A_LOW,   B_LP,   ACC_HOLD, WR_NONE, JMP_NEXT);
         5:  w = uw(1'b1, A_HIGH,  B_DIFF, ACC_LOAD, WR_NONE, JMP_NEXT);
         6:  w = uw(1'b0, A_FEED,  B_X,    ACC_ADD,  WR_NONE, JMP_NEXT);
         7:  w = uw(1'b0, A_FEED,  B_X,    ACC_HOLD, WR_Y,    JMP_NEXT);
         8:  w = uw(1'b1, A_OUT,   B_Y,    ACC_HOLD, WR_NONE, JMP_NEXT);
         9:  w = uw(1'b0, A_FEED,  B_X,    ACC_LOAD, WR_NONE, JMP_NEXT);
         10: w = uw(1'b0, A_FEED,  B_X,    ACC_HOLD, WR_OUT,  JMP_CHAN);
         11: w = uw(1'b0, A_FEED,  B_X,    ACC_HOLD, WR_NONE, JMP_EMIT);
         default: w = uw(1'b0, A_FEED, B_X, ACC_HOLD, WR_NONE, JMP_EMIT);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: src/steq_channels.sv
// Handshake channel interfaces: sample input, result output, register writes.
`default_nettype none
interface steq_req_if;
   import steq_pkg::*;
   logic       valid;
   logic       ready;
   sample_type left_sample;
   sample_type right_sample;
   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface steq_rsp_if;
   import steq_pkg::*;
   logic       valid;
   logic       ready;
   sample_type left_result;
   sample_type right_result;
   logic       clipped;
   modport source (output valid, output left_result, output right_result,
                   output clipped, input ready);
   modport sink   (input valid, input left_result, input right_result,
                   input clipped, output ready);
endinterface

interface steq_csr_if;
   import steq_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/steq_csr.sv
// Configuration register file.
`default_nettype none
module steq_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   steq_csr_if.sink           csr_chan,
   output steq_pkg::cfg_type  cfg
);
   import steq_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MONO_MODE:     cfg_in.mono_mode     = csr_chan.data[0];
            CSR_FEED_COEF:     cfg_in.feed_coef     = csr_chan.data[COEF_BITS-1:0];
            CSR_FEEDBACK_COEF: cfg_in.feedback_coef = csr_chan.data[COEF_BITS-1:0];
            CSR_LOW_GAIN:      cfg_in.low_gain      = csr_chan.data[COEF_BITS-1:0];
            CSR_HIGH_GAIN:     cfg_in.high_gain     = csr_chan.data[COEF_BITS-1:0];
            CSR_OUTPUT_GAIN:   cfg_in.output_gain   = csr_chan.data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mono_mode     <= 1'b0;
         cfg_ff.feed_coef     <= '0;
         cfg_ff.feedback_coef <= '0;
         cfg_ff.low_gain      <= '0;
         cfg_ff.high_gain     <= '0;
         cfg_ff.output_gain   <= UNITY_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/steq_sequencer.sv
// Microcode sequencer: step counter, channel select and jump logic.
`default_nettype none
module steq_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                mono,
   input  wire logic                out_free,
   output steq_pkg::ctrl_type       ctrl,
   output steq_pkg::seq_status_type status
);
   import steq_pkg::*;

   logic      busy_ff, busy_in;
   logic      chan_ff, chan_in;
   pc_type    pc_ff, pc_in;
   uword_type word;
   logic      emit;

   always_comb begin
      word    = ucode_rom(pc_ff);
      busy_in = busy_ff;
      chan_in = chan_ff;
      pc_in   = pc_ff;
      emit    = 1'b0;
      if (busy_ff) begin
         unique case (word.jmp)
            JMP_NEXT: pc_in = pc_ff + 1'b1;
            JMP_CHAN: begin
               if (!mono && !chan_ff) begin
                  pc_in   = PC_ENTRY;
                  chan_in = 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            JMP_EMIT: begin
               // hold here until the output register can take the result
               if (out_free) begin
                  emit    = 1'b1;
                  busy_in = 1'b0;
                  pc_in   = PC_ENTRY;
               end
            end
            default: pc_in = PC_ENTRY;
         endcase
      end else if (start) begin
         busy_in = 1'b1;
         chan_in = 1'b0;
         pc_in   = PC_ENTRY;
      end
   end

   always_comb begin
      ctrl.mul_en = busy_ff & word.mul_en;
      ctrl.a_sel  = word.a_sel;
      ctrl.b_sel  = word.b_sel;
      ctrl.acc_op = busy_ff ? word.acc_op : ACC_HOLD;
      ctrl.wr_op  = busy_ff ? word.wr_op : WR_NONE;
      ctrl.chan   = chan_ff;
      status.busy = busy_ff;
      status.chan = chan_ff;
      status.emit = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chan_ff <= 1'b0;
         pc_ff   <= PC_ENTRY;
      end else begin
         busy_ff <= busy_in;
         chan_ff <= chan_in;
         pc_ff   <= pc_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/steq_datapath.sv
// Shared multiply-accumulate datapath with filter state and result registers.
`default_nettype none
module steq_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  steq_pkg::sample_type    left_sample,
   input  steq_pkg::sample_type    right_sample,
   input  steq_pkg::cfg_type       cfg,
   input  steq_pkg::ctrl_type      ctrl,
   output steq_pkg::result_type    result
);
   import steq_pkg::*;

   localparam logic signed [ACC_BITS-1:0] RND_HALF =
      {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [RND_BITS-1:0] LP_HI  = RND_BITS'({1'b0, {(STATE_BITS-1){1'b1}}});
   localparam logic signed [RND_BITS-1:0] LP_LO  = ~LP_HI;
   localparam logic signed [RND_BITS-1:0] OUT_HI = RND_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [RND_BITS-1:0] OUT_LO = ~OUT_HI;

   sample_type                   x_ff [2];
   state_type                    lp_ff [2];
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [Y_BITS-1:0]     y_ff;
   sample_type                   resl_ff, resr_ff;
   logic                         clip_ff;

   sample_type                   x_cur, avg;
   state_type                    lp_cur, lp_sat;
   logic signed [SAMPLE_BITS:0]  pair_sum;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [ACC_BITS-1:0]   rnd_full;
   logic signed [RND_BITS-1:0]   rnd;
   sample_type                   out_sat;
   logic                         out_hit;

   assign pair_sum = (SAMPLE_BITS+1)'(left_sample) + (SAMPLE_BITS+1)'(right_sample);
   assign avg      = pair_sum[SAMPLE_BITS:1];
   assign x_cur    = x_ff[ctrl.chan];
   assign lp_cur   = lp_ff[ctrl.chan];
   assign diff     = DIFF_BITS'(x_cur) - DIFF_BITS'(lp_cur);

   always_comb begin
      unique case (ctrl.a_sel)
         A_FEED:  mul_a = MUL_A_BITS'(cfg.feed_coef);
         A_FBACK: mul_a = MUL_A_BITS'(cfg.feedback_coef);
         A_LOW:   mul_a = MUL_A_BITS'(cfg.low_gain);
         A_HIGH:  mul_a = MUL_A_BITS'(cfg.high_gain);
         A_OUT:   mul_a = {1'b0, cfg.output_gain};
         default: mul_a = '0;
      endcase
      unique case (ctrl.b_sel)
         B_X:     mul_b = MUL_B_BITS'(x_cur);
         B_LP:    mul_b = MUL_B_BITS'(lp_cur);
         B_DIFF:  mul_b = MUL_B_BITS'(diff);
         B_Y:     mul_b = MUL_B_BITS'(y_ff);
         default: mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = ACC_BITS'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_BITS'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   // round half up, then floor by the fraction width
   assign rnd_full = acc_ff + RND_HALF;
   assign rnd      = rnd_full[ACC_BITS-1:COEF_FRAC_BITS];

   always_comb begin
      if (rnd > LP_HI) begin
         lp_sat = {1'b0, {(STATE_BITS-1){1'b1}}};
      end else if (rnd < LP_LO) begin
         lp_sat = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         lp_sat = rnd[STATE_BITS-1:0];
      end
      out_hit = 1'b1;
      if (rnd > OUT_HI) begin
         out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (rnd < OUT_LO) begin
         out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         out_sat = rnd[SAMPLE_BITS-1:0];
         out_hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff[0] <= '0;
         lp_ff[1] <= '0;
      end else if (ctrl.wr_op == WR_LP) begin
         lp_ff[ctrl.chan] <= lp_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff[0] <= cfg.mono_mode ? avg : left_sample;
         x_ff[1] <= right_sample;
         clip_ff <= 1'b0;
      end else if (ctrl.wr_op == WR_OUT) begin
         clip_ff <= clip_ff | out_hit;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (ctrl.wr_op == WR_Y) begin
         y_ff <= Y_BITS'(x_cur) + Y_BITS'(rnd);
      end
      if (ctrl.wr_op == WR_OUT) begin
         if (ctrl.chan) begin
            resr_ff <= out_sat;
         end else begin
            resl_ff <= out_sat;
         end
      end
   end

   assign result.left  = resl_ff;
   assign result.right = cfg.mono_mode ? resl_ff : resr_ff;
   assign result.clip  = clip_ff;

endmodule
`default_nettype wire

FILE: src/stereo_tilt_equalizer_unit.sv
// Top level of the stereo tilt equalizer.
//
//   channel   dir  payload                                   transfer when
//   req_chan  in   left_sample, right_sample                 valid & ready
//   rsp_chan  out  left_result, right_result, clipped        valid & ready
//   csr_chan  in   index, data                               valid & ready (ready tied high)
//
// Items are processed one at a time on the single shared multiplier: 11 microcode
// steps per channel (one channel in mono mode), one emit step and the idle state in
// which the next item is taken; no new item is taken while the sequencer is busy.
// Reset clears the filter state and loads the register reset values; no clearing pass.
// A finished result sits in the output register while the next item is taken; a
// result that cannot leave stalls the sequencer on its emit step.
`default_nettype none
`include "stereo_tilt_equalizer_unit_macros.svh"
module stereo_tilt_equalizer_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   steq_req_if.sink    req_chan,
   steq_rsp_if.source  rsp_chan,
   steq_csr_if.sink    csr_chan
);
   import steq_pkg::*;

   cfg_type        cfg;
   ctrl_type       ctrl;
   seq_status_type status;
   result_type     result;
   logic           start;
   logic           out_free;

   logic           rsp_valid_ff, rsp_valid_in;
   sample_type     rsp_left_ff, rsp_right_ff;
   logic           rsp_clip_ff;

   assign req_chan.ready = !status.busy;
   assign start          = req_chan.valid & req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   steq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   steq_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .mono     (cfg.mono_mode),
      .out_free (out_free),
      .ctrl     (ctrl),
      .status   (status)
   );

   steq_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .left_sample  (req_chan.left_sample),
      .right_sample (req_chan.right_sample),
      .cfg          (cfg),
      .ctrl         (ctrl),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.emit) begin
         rsp_left_ff  <= result.left;
         rsp_right_ff <= result.right;
         rsp_clip_ff  <= result.clip;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_result  = rsp_left_ff;
   assign rsp_chan.right_result = rsp_right_ff;
   assign rsp_chan.clipped      = rsp_clip_ff;

   `STEQ_ASSERT_NEXT(a_start_busy, clock, reset, start, status.busy, "item taken but sequencer idle")
   `STEQ_ASSERT_NOW(a_emit_free, clock, reset, status.emit, out_free, "result emitted over a pending one")
   `STEQ_ASSERT_NEXT(a_emit_valid, clock, reset, status.emit, rsp_valid_ff, "emitted result not presented")

endmodule
`default_nettype wire
